// ===== hdl/rsmm_pkg.sv =====
// Package for the record stack with running min/max tracking.
// Holds the stack sizing, request and status codes, and the level record type.
// No dependencies.
`default_nettype none

package rsmm_pkg;

    localparam int STACK_DEPTH = 64;
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int ID_W  = 32;
    localparam int VAL_W = 16;

    // Stream payload widths (tdata in whole bytes)
    localparam int S_DATA_W = 48;
    localparam int S_USER_W = 1;
    localparam int M_DATA_W = 104;
    localparam int M_USER_W = 2;

    typedef enum logic [0:0] {
        FUNC_PUSH = 1'b0,
        FUNC_POP  = 1'b1
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_UNDERFLOW = 2'd1,
        ST_OVERFLOW  = 2'd2
    } t_status;

    // One stack level: its own record and the max/min record at or below it
    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] val;
        logic [ID_W-1:0]  max_id;
        logic [VAL_W-1:0] max_val;
        logic [ID_W-1:0]  min_id;
        logic [VAL_W-1:0] min_val;
    } t_level;

    typedef struct packed {
        t_status          status;
        logic [CNT_W-1:0] depth;
        logic             is_empty;
        logic [ID_W-1:0]  max_id;
        logic [VAL_W-1:0] max_val;
        logic [ID_W-1:0]  min_id;
        logic [VAL_W-1:0] min_val;
    } t_result;

endpackage

`default_nettype wire

// ===== hdl/record_stack_with_min_max.sv =====
// Top level of the record stack with min/max: one push or pop per request.
// Depends on rsmm_pkg for sizing, codes and the level record type.
//
//  channel   dir  handshake                       payload
//  s_axis    in   i_s_axis_tvalid/o_s_axis_tready tdata {entry_value, entry_id}, tuser func
//  m_axis    out  o_m_axis_tvalid/i_m_axis_tready tdata {min,max,is_empty,depth}, tuser status
//
// One request per cycle while input ready is high; each result is registered on acceptance.
// The top level and the level below it sit in registers, so a pop never waits
// on the level memory: its single registered read fetches the level two below.
// Reset (synchronous, active low) empties the stack; the level memory is not cleared.
// A two-entry output buffer lets one request in while a result is stalled;
// input ready drops only when both entries are held.
`default_nettype none

module record_stack_with_min_max (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    // [31:0] entry_id, [47:32] entry_value
    input  wire  [rsmm_pkg::S_DATA_W-1:0] i_s_axis_tdata,
    // [0] func
    input  wire  [rsmm_pkg::S_USER_W-1:0] i_s_axis_tuser,
    output logic                          o_m_axis_tvalid,
    input  wire                           i_m_axis_tready,
    // [6:0] depth, [7] is_empty, [39:8] max_id, [55:40] max_value,
    // [87:56] min_id, [103:88] min_value
    output logic [rsmm_pkg::M_DATA_W-1:0] o_m_axis_tdata,
    // [1:0] status
    output logic [rsmm_pkg::M_USER_W-1:0] o_m_axis_tuser
);

    import rsmm_pkg::*;

    // Level memory: holds every level below the top level
    t_level mem_levels [STACK_DEPTH];

    logic [CNT_W-1:0] r_count, n_count;
    t_level           r_top, n_top;
    t_level           r_copy;
    logic             r_use_copy;
    t_level           r_rd_data;
    t_level           below;

    t_result          r_out, r_skid, result;
    logic             r_out_valid, r_skid_valid;

    logic             accept, out_fire;
    t_func            func;
    logic [ID_W-1:0]  req_id;
    logic [VAL_W-1:0] req_val;
    logic             is_full, is_zero;
    logic             do_push, do_pop;
    logic [ADDR_W-1:0] wr_addr, rd_addr;
    logic [CNT_W-1:0] cnt_m1, cnt_m3;

    // Unpack the request
    assign func    = t_func'(i_s_axis_tuser[0]);
    assign req_id  = i_s_axis_tdata[ID_W-1:0];
    assign req_val = i_s_axis_tdata[ID_W +: VAL_W];

    assign o_s_axis_tready = ~r_skid_valid;
    assign accept   = i_s_axis_tvalid & o_s_axis_tready;
    assign out_fire = r_out_valid & i_m_axis_tready;

    assign is_full = (r_count == CNT_W'(STACK_DEPTH));
    assign is_zero = (r_count == '0);
    assign do_push = accept & (func == FUNC_PUSH) & ~is_full;
    assign do_pop  = accept & (func == FUNC_POP) & ~is_zero;

    assign cnt_m1  = r_count - CNT_W'(1);
    assign cnt_m3  = r_count - CNT_W'(3);
    assign wr_addr = cnt_m1[ADDR_W-1:0];
    assign rd_addr = cnt_m3[ADDR_W-1:0];

    // Level just below the top: fresh copy after a push, memory data after a pop
    assign below = r_use_copy ? r_copy : r_rd_data;

    // Next top level, count and result
    always_comb begin
        n_top   = r_top;
        n_count = r_count;
        result  = '0;
        if (do_push) begin
            n_top.id  = req_id;
            n_top.val = req_val;
            if (!is_zero && (req_val < r_top.max_val)) begin
                n_top.max_id  = r_top.max_id;
                n_top.max_val = r_top.max_val;
            end else begin
                n_top.max_id  = req_id;
                n_top.max_val = req_val;
            end
            if (!is_zero && (req_val > r_top.min_val)) begin
                n_top.min_id  = r_top.min_id;
                n_top.min_val = r_top.min_val;
            end else begin
                n_top.min_id  = req_id;
                n_top.min_val = req_val;
            end
            n_count = r_count + CNT_W'(1);
        end else if (do_pop) begin
            n_top   = below;
            n_count = cnt_m1;
        end

        priority if (func == FUNC_PUSH && is_full) begin
            result.status = ST_OVERFLOW;
        end else if (func == FUNC_POP && is_zero) begin
            result.status = ST_UNDERFLOW;
        end else begin
            result.status = ST_DONE;
        end
        result.depth    = n_count;
        result.is_empty = (n_count == '0);
        if (n_count != '0) begin
            result.max_id  = n_top.max_id;
            result.max_val = n_top.max_val;
            result.min_id  = n_top.min_id;
            result.min_val = n_top.min_val;
        end
    end

    // Spill the old top into memory on push
    always_ff @(posedge i_clk) begin
        if (do_push && !is_zero) begin
            mem_levels[wr_addr] <= r_top;
        end
    end

    // Fetch the level two below the top on pop
    always_ff @(posedge i_clk) begin
        if (do_pop) begin
            r_rd_data <= mem_levels[rd_addr];
        end
    end

    // Top level and copy of the level below
    always_ff @(posedge i_clk) begin
        r_top <= n_top;
        if (do_push) begin
            r_copy <= r_top;
        end
    end

    // Count and below-source select
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_use_copy <= 1'b0;
        end else begin
            r_count <= n_count;
            if (do_push) begin
                r_use_copy <= 1'b1;
            end else if (do_pop) begin
                r_use_copy <= 1'b0;
            end
        end
    end

    // Output register with skid entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (out_fire || !r_out_valid) begin
            r_out_valid  <= r_skid_valid | accept;
            r_skid_valid <= 1'b0;
        end else if (accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_out_valid) begin
            r_out <= r_skid_valid ? r_skid : result;
        end else if (accept) begin
            r_skid <= result;
        end
    end

    // Pack the result
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.status;
    assign o_m_axis_tdata  = {r_out.min_val, r_out.min_id, r_out.max_val, r_out.max_id,
                              r_out.is_empty, r_out.depth};

    // Checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(STACK_DEPTH))
        else $error("stack count above depth");

    a_skid_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held without output entry");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && func == FUNC_PUSH && is_full) |=> (r_count == CNT_W'(STACK_DEPTH)))
        else $error("refused push changed the count");

    a_pop_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_pop |=> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not drop the count by one");

    a_push_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_push |=> (r_use_copy && r_top.max_val >= r_top.val && r_top.min_val <= r_top.val))
        else $error("pushed top level breaks max/min order");

endmodule

`default_nettype wire

// ===== sim/tb_record_stack_with_min_max.sv =====
// Testbench for record_stack_with_min_max: streams push/pop requests, predicts every
// result with its own stack model and compares each result field by field.
// Depends on rsmm_pkg for widths, request and status codes and the result record.
module tb_record_stack_with_min_max;
    timeunit 1ns;
    timeprecision 1ps;
    import rsmm_pkg::*;

    localparam int NUM_RANDOM   = 1330;
    localparam int LIMIT_CYCLES = 300000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTED = 10;

    typedef struct packed {
        t_func            func;
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] val;
    } t_request;

    typedef enum int {GEN_FILL, GEN_DRAIN, GEN_CHURN} t_gen_mode;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_s_axis_tvalid = 1'b0;
    logic                o_s_axis_tready;
    logic [S_DATA_W-1:0] i_s_axis_tdata = '0;   // [31:0] entry_id, [47:32] entry_value
    logic [S_USER_W-1:0] i_s_axis_tuser = '0;   // [0] func
    logic                o_m_axis_tvalid;
    logic                i_m_axis_tready = 1'b0;
    // [6:0] depth, [7] is_empty, [39:8] max_id, [55:40] max_value,
    // [87:56] min_id, [103:88] min_value
    logic [M_DATA_W-1:0] o_m_axis_tdata;
    logic [M_USER_W-1:0] o_m_axis_tuser;        // [1:0] status

    // Requests waiting to be sent and results waiting to arrive
    t_request request_q[$];
    t_result  report_q[$];

    // Stack model: each level keeps its record and where the max/min at or below it sits
    logic [ID_W-1:0]   lvl_id     [STACK_DEPTH];
    logic [VAL_W-1:0]  lvl_val    [STACK_DEPTH];
    logic [ADDR_W-1:0] lvl_max_at [STACK_DEPTH];
    logic [ADDR_W-1:0] lvl_min_at [STACK_DEPTH];
    logic [CNT_W-1:0]  held;

    t_request cur_req;
    int       idle_phase = 0;
    int       total_requests = 0;
    int       n_sent = 0, n_checked = 0, fail_count = 0, cycles = 0;
    int       n_push = 0, n_pop = 0, n_overflow = 0, n_underflow = 0, n_full = 0;
    int       gen_depth = 0;

    record_stack_with_min_max dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one request to the stack model and build the result it must produce
    task automatic apply_request(input t_request rq, output t_result res);
        logic [ADDR_W-1:0] mx, mn, top, prev;
        res = '0;
        res.status = ST_DONE;
        if (rq.func == FUNC_PUSH) begin
            n_push++;
            if (held == CNT_W'(STACK_DEPTH)) begin
                res.status = ST_OVERFLOW;
                n_overflow++;
            end else begin
                mx = held[ADDR_W-1:0];
                mn = held[ADDR_W-1:0];
                // the new record wins ties, so the older one is kept only when strictly better
                if (held != 0) begin
                    prev = ADDR_W'(held - 1'b1);
                    if (rq.val < lvl_val[lvl_max_at[prev]]) mx = lvl_max_at[prev];
                    if (rq.val > lvl_val[lvl_min_at[prev]]) mn = lvl_min_at[prev];
                end
                lvl_id[held[ADDR_W-1:0]]     = rq.id;
                lvl_val[held[ADDR_W-1:0]]    = rq.val;
                lvl_max_at[held[ADDR_W-1:0]] = mx;
                lvl_min_at[held[ADDR_W-1:0]] = mn;
                held = held + 1'b1;
                if (held == CNT_W'(STACK_DEPTH)) n_full++;
            end
        end else begin
            n_pop++;
            if (held == 0) begin
                res.status = ST_UNDERFLOW;
                n_underflow++;
            end else begin
                held = held - 1'b1;
            end
        end
        res.depth    = held;
        res.is_empty = (held == 0);
        // empty stack reports zero records
        if (held != 0) begin
            top = ADDR_W'(held - 1'b1);
            res.max_id  = lvl_id[lvl_max_at[top]];
            res.max_val = lvl_val[lvl_max_at[top]];
            res.min_id  = lvl_id[lvl_min_at[top]];
            res.min_val = lvl_val[lvl_min_at[top]];
        end
    endtask

    // Compare one arrived result with the oldest expectation
    task automatic check_report(input t_result got);
        t_result want;
        if (report_q.size() == 0) begin
            fail_count++;
            if (fail_count <= MAX_REPORTED)
                $display("ERROR: result with nothing expected: status=%0d depth=%0d",
                         got.status, got.depth);
        end else begin
            want = report_q.pop_front();
            n_checked++;
            if (got.status !== want.status || got.depth !== want.depth ||
                got.is_empty !== want.is_empty || got.max_id !== want.max_id ||
                got.max_val !== want.max_val || got.min_id !== want.min_id ||
                got.min_val !== want.min_val) begin
                fail_count++;
                if (fail_count <= MAX_REPORTED) begin
                    $display("ERROR: result %0d expected st=%0d dp=%0d em=%0b max=%h/%h min=%h/%h",
                             n_checked, want.status, want.depth, want.is_empty,
                             want.max_id, want.max_val, want.min_id, want.min_val);
                    $display("       got             st=%0d dp=%0d em=%0b max=%h/%h min=%h/%h",
                             got.status, got.depth, got.is_empty,
                             got.max_id, got.max_val, got.min_id, got.min_val);
                end
            end
        end
    endtask

    function automatic int send_idle_pct(int phase);
        return (phase == 0) ? 7 : (phase == 1) ? 76 : 0;
    endfunction

    function automatic int recv_idle_pct(int phase);
        return (phase == 0) ? 76 : (phase == 1) ? 7 : 0;
    endfunction

    // Driver: predict on every accepted request, then offer the next one or idle
    always @(posedge i_clk) begin : driver
        t_result  res;
        t_request rq;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            held = '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                apply_request(cur_req, res);
                report_q.push_back(res);
                n_sent++;
            end
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (request_q.size() != 0 &&
                    $urandom_range(0, 99) >= send_idle_pct(idle_phase)) begin
                    rq = request_q.pop_front();
                    cur_req = rq;
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata  <= {rq.val, rq.id};
                    i_s_axis_tuser  <= rq.func;
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
            // advance the idling pattern by thirds of the run
            if (n_sent < total_requests / 3)
                idle_phase <= 0;
            else if (n_sent < 2 * total_requests / 3)
                idle_phase <= 1;
            else
                idle_phase <= 2;
        end
    end

    // Monitor: check every accepted result, stall at random
    always @(posedge i_clk) begin : monitor
        t_result got;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                got.status   = t_status'(o_m_axis_tuser[1:0]);
                got.depth    = o_m_axis_tdata[6:0];
                got.is_empty = o_m_axis_tdata[7];
                got.max_id   = o_m_axis_tdata[39:8];
                got.max_val  = o_m_axis_tdata[55:40];
                got.min_id   = o_m_axis_tdata[87:56];
                got.min_val  = o_m_axis_tdata[103:88];
                check_report(got);
            end
            i_m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct(idle_phase));
        end
    end

    // Hard stop if the block hangs
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > LIMIT_CYCLES) begin
            $display("ERROR: timeout after %0d cycles, %0d results pending",
                     cycles, report_q.size());
            $display("record_stack_with_min_max regression: fail");
            $finish;
        end
    end

    task automatic add_request(input t_func func, input logic [ID_W-1:0] id,
                               input logic [VAL_W-1:0] val);
        t_request rq;
        rq.func = func;
        rq.id   = id;
        rq.val  = val;
        request_q.push_back(rq);
        if (func == FUNC_PUSH && gen_depth < STACK_DEPTH) gen_depth++;
        if (func == FUNC_POP && gen_depth > 0) gen_depth--;
    endtask

    // Values lean on the extremes and a narrow band so ties are frequent
    function automatic logic [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2, 3:    return VAL_W'($urandom_range(0, 7));
            default: return VAL_W'($urandom);
        endcase
    endfunction

    initial begin
        t_gen_mode mode;
        int        extra_left;
        int        churn_left;
        bit        do_push;

        // Directed: pop of empty, extreme fields, ties, pop of the last record
        add_request(FUNC_POP,  $urandom, 16'(($urandom)));
        add_request(FUNC_PUSH, 32'hFFFF_FFFF, 16'h0000);
        add_request(FUNC_PUSH, 32'h0000_0000, 16'hFFFF);
        add_request(FUNC_PUSH, 32'h0000_0001, 16'hFFFF);
        add_request(FUNC_PUSH, 32'h0000_0002, 16'h0000);
        add_request(FUNC_PUSH, 32'h0000_0003, 16'h8000);
        add_request(FUNC_PUSH, 32'h0000_0004, 16'h8000);
        add_request(FUNC_POP,  32'hFFFF_FFFF, 16'hFFFF);
        add_request(FUNC_POP,  $urandom, 16'($urandom));
        add_request(FUNC_POP,  $urandom, 16'($urandom));
        add_request(FUNC_POP,  $urandom, 16'($urandom));
        add_request(FUNC_POP,  $urandom, 16'($urandom));
        add_request(FUNC_POP,  $urandom, 16'($urandom));
        add_request(FUNC_POP,  $urandom, 16'($urandom));
        add_request(FUNC_PUSH, 32'hAAAA_AAAA, 16'h5555);
        add_request(FUNC_PUSH, 32'h5555_5555, 16'hAAAA);
        add_request(FUNC_POP,  32'h0000_0000, 16'h0000);
        add_request(FUNC_POP,  $urandom, 16'($urandom));

        // Random: fill to overflow, drain to underflow, and churn around the middle
        mode = GEN_FILL;
        extra_left = $urandom_range(1, 3);
        churn_left = 0;
        for (int k = 0; k < NUM_RANDOM; k++) begin
            if ((mode == GEN_FILL && gen_depth == STACK_DEPTH && extra_left == 0) ||
                (mode == GEN_DRAIN && gen_depth == 0 && extra_left == 0) ||
                (mode == GEN_CHURN && churn_left == 0)) begin
                case ($urandom_range(0, 2))
                    0:       mode = GEN_FILL;
                    1:       mode = GEN_DRAIN;
                    default: mode = GEN_CHURN;
                endcase
                extra_left = $urandom_range(1, 3);
                churn_left = $urandom_range(10, 60);
            end
            case (mode)
                GEN_FILL: begin
                    if (gen_depth == STACK_DEPTH) begin
                        do_push = 1'b1;
                        extra_left--;
                    end else begin
                        do_push = ($urandom_range(0, 99) < 85);
                    end
                end
                GEN_DRAIN: begin
                    if (gen_depth == 0) begin
                        do_push = 1'b0;
                        extra_left--;
                    end else begin
                        do_push = ($urandom_range(0, 99) < 15);
                    end
                end
                default: begin
                    churn_left--;
                    do_push = 1'($urandom_range(0, 1));
                end
            endcase
            add_request(do_push ? FUNC_PUSH : FUNC_POP, $urandom, pick_value());
        end
        total_requests = request_q.size();

        // Hold reset, then release it once
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Drain: every request sent and every result back
        @(negedge i_clk);
        while (request_q.size() != 0 || i_s_axis_tvalid || report_q.size() != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Covered %0d requests (%0d pushes, %0d pops), %0d results checked",
                 n_sent, n_push, n_pop, n_checked);
        $display("Stack filled %0d times, %0d overflows, %0d underflows, %0d mismatches",
                 n_full, n_overflow, n_underflow, fail_count);
        if (fail_count == 0 && report_q.size() == 0) begin
            $display("record_stack_with_min_max regression: pass");
        end else begin
            $display("record_stack_with_min_max regression: fail");
        end
        $finish;
    end

endmodule

// ===== files.f =====
hdl/rsmm_pkg.sv
hdl/record_stack_with_min_max.sv
sim/tb_record_stack_with_min_max.sv
